// File: hdl/eds_pkg.sv
// ----------------------------------------------------------------------------
// eds_pkg
// Shared types and codes for the elevator dispatch scheduler.
// ----------------------------------------------------------------------------
package eds_pkg;

    // Input item types.
    localparam logic [2:0] REQ_FLOOR    = 3'd0;
    localparam logic [2:0] REQ_DISPATCH = 3'd1;
    localparam logic [2:0] REQ_STATUS   = 3'd2;
    localparam logic [2:0] REQ_TRIP     = 3'd3;
    localparam logic [2:0] REQ_FAULT    = 3'd4;

    // Result kinds.
    localparam logic [1:0] KIND_ASSIGN  = 2'd0;
    localparam logic [1:0] KIND_NO_CAR  = 2'd1;
    localparam logic [1:0] KIND_NOTIFY  = 2'd2;
    localparam logic [1:0] KIND_DROPPED = 2'd3;

    localparam logic [3:0] PENALTY_RESET = 4'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [5:0] floor;
        logic [5:0] dest_floor;
        logic       going_up;
        logic [1:0] fault_flag;
        logic [2:0] elevator_id;
        logic [5:0] trip_pickup;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [2:0] car_id;
        logic [5:0] origin_floor;
        logic [5:0] pickup_floor;
        logic [5:0] target_floor;
        logic       dir_up;
        logic [1:0] fault_tag;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;     // capture the accepted beat
        logic execute;   // apply a non-dispatch item
        logic pop;       // fetch and pop the head request
        logic scan;      // compare the current car
        logic commit;    // apply the assignment and form the result
    } eds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_request;  // some FIFO holds a request
        logic scan_last;    // current car is the last one
        logic has_result;   // executed item produced a result
    } eds_sts_t;

endpackage

// File: hdl/eds_stream_if.sv
// ----------------------------------------------------------------------------
// eds_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface eds_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/eds_datapath.sv
// ----------------------------------------------------------------------------
// eds_datapath
// Request FIFOs, car table, sequential best-car search and result forming.
// ----------------------------------------------------------------------------
module eds_datapath #(
    parameter int NUM_CARS   = 8,
    parameter int FIFO_DEPTH = 16,
    parameter int FLOOR_BITS = 6,
    parameter int LOAD_BITS  = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  eds_pkg::eds_cmd_t    cmd,
    output eds_pkg::eds_sts_t    sts,
    input  eds_pkg::in_item_t    in_data,
    input  logic                 cfg_we,
    input  logic [3:0]           cfg_wdata,
    output eds_pkg::out_item_t   result
);
    localparam int CAR_W  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int DIST_W = FLOOR_BITS + 1;
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = '1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);

    typedef struct packed {
        logic [FLOOR_BITS-1:0] floor;
        logic [FLOOR_BITS-1:0] dest;
        logic [1:0]            tag;
    } call_t;

    // Captured item and configuration.
    eds_pkg::in_item_t item_reg;
    logic [3:0]        penalty_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            penalty_reg <= eds_pkg::PENALTY_RESET;
        end
        else if (cfg_we)
        begin
            penalty_reg <= cfg_wdata;
        end
    end

    logic [FLOOR_BITS-1:0] it_floor, it_dest, it_pick;
    logic [2:0]            it_id;
    logic                  id_ok;
    assign it_floor = item_reg.floor[FLOOR_BITS-1:0];
    assign it_dest  = item_reg.dest_floor[FLOOR_BITS-1:0];
    assign it_pick  = item_reg.trip_pickup[FLOOR_BITS-1:0];
    assign it_id    = item_reg.elevator_id;
    assign id_ok    = ({29'd0, it_id} < 32'(NUM_CARS));
    logic [CAR_W-1:0] id_idx;
    assign id_idx = CAR_W'(it_id);

    // Circular FIFOs in memories, pointers and counts in flops.
    call_t up_mem [FIFO_DEPTH];
    call_t dn_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] up_wp_reg, up_rp_reg, dn_wp_reg, dn_rp_reg;
    logic [CNT_W-1:0] up_cnt_reg, dn_cnt_reg;
    call_t up_rd_reg, dn_rd_reg;
    logic  push_up, push_dn, pop_up, pop_dn, up_full, dn_full;

    assign up_full = (up_cnt_reg == DEPTH_C);
    assign dn_full = (dn_cnt_reg == DEPTH_C);
    assign push_up = cmd.execute && item_reg.req_type == eds_pkg::REQ_FLOOR
                     && item_reg.going_up && !up_full;
    assign push_dn = cmd.execute && item_reg.req_type == eds_pkg::REQ_FLOOR
                     && !item_reg.going_up && !dn_full;
    assign pop_up  = cmd.pop && up_cnt_reg != '0;
    assign pop_dn  = cmd.pop && up_cnt_reg == '0 && dn_cnt_reg != '0;
    assign sts.has_request = (up_cnt_reg != '0) || (dn_cnt_reg != '0);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push_up)
        begin
            up_mem[up_wp_reg] <= '{it_floor, it_dest, item_reg.fault_flag};
        end
        if (push_dn)
        begin
            dn_mem[dn_wp_reg] <= '{it_floor, it_dest, item_reg.fault_flag};
        end
        up_rd_reg <= up_mem[up_rp_reg];
        dn_rd_reg <= dn_mem[dn_rp_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_wp_reg  <= '0;
            up_rp_reg  <= '0;
            dn_wp_reg  <= '0;
            dn_rp_reg  <= '0;
            up_cnt_reg <= '0;
            dn_cnt_reg <= '0;
        end
        else
        begin
            if (push_up)
            begin
                up_wp_reg  <= ptr_inc(up_wp_reg);
                up_cnt_reg <= up_cnt_reg + 1'b1;
            end
            if (pop_up)
            begin
                up_rp_reg  <= ptr_inc(up_rp_reg);
                up_cnt_reg <= up_cnt_reg - 1'b1;
            end
            if (push_dn)
            begin
                dn_wp_reg  <= ptr_inc(dn_wp_reg);
                dn_cnt_reg <= dn_cnt_reg + 1'b1;
            end
            if (pop_dn)
            begin
                dn_rp_reg  <= ptr_inc(dn_rp_reg);
                dn_cnt_reg <= dn_cnt_reg - 1'b1;
            end
        end
    end

    // Which FIFO the head came from; the read register holds the head in the cycle after the pop.
    logic req_up_reg, sel_pend_reg;
    call_t rq_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.pop)
        begin
            req_up_reg <= pop_up;
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_pend_reg <= 1'b0;
        end
        else
        begin
            sel_pend_reg <= cmd.pop;
        end
    end
    always_ff @(posedge clk)
    begin
        if (sel_pend_reg)
        begin
            rq_reg <= req_up_reg ? up_rd_reg : dn_rd_reg;
        end
    end

    // Car table.
    logic [FLOOR_BITS-1:0] car_floor_reg [NUM_CARS];
    logic [FLOOR_BITS-1:0] car_prev_reg  [NUM_CARS];
    logic [LOAD_BITS-1:0]  car_load_reg  [NUM_CARS];
    logic [NUM_CARS-1:0]   car_known_reg, car_faulty_reg, car_dir_up_reg, car_dir_ok_reg;

    // Scan state.
    logic [CAR_W-1:0]     scan_idx_reg, best_idx_reg;
    logic                 best_ok_reg;
    logic [LOAD_BITS-1:0] best_load_reg;
    logic [DIST_W+3:0]    best_dist_reg;
    assign sts.scan_last = (32'(scan_idx_reg) == NUM_CARS - 1);

    logic [DIST_W+3:0] car_cost;
    logic              elig, better;
    always_comb
    begin
        logic [FLOOR_BITS-1:0] cf;
        cf = car_floor_reg[scan_idx_reg];
        car_cost = (cf > rq_reg.floor) ? (DIST_W+4)'(cf - rq_reg.floor)
                                       : (DIST_W+4)'(rq_reg.floor - cf);
        if (car_dir_ok_reg[scan_idx_reg] && car_dir_up_reg[scan_idx_reg] != req_up_reg)
        begin
            car_cost = car_cost + (DIST_W+4)'(penalty_reg);
        end
        elig = car_known_reg[scan_idx_reg] && !car_faulty_reg[scan_idx_reg];
        better = elig && (!best_ok_reg || car_load_reg[scan_idx_reg] < best_load_reg
                 || (car_load_reg[scan_idx_reg] == best_load_reg
                     && car_cost < best_dist_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            best_ok_reg  <= 1'b0;
        end
        else if (cmd.pop)
        begin
            scan_idx_reg <= '0;
            best_ok_reg  <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (!sts.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (better)
            begin
                best_ok_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan && better)
        begin
            best_idx_reg  <= scan_idx_reg;
            best_load_reg <= car_load_reg[scan_idx_reg];
            best_dist_reg <= car_cost;
        end
    end

    // Car table updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            car_known_reg  <= '0;
            car_faulty_reg <= '0;
            car_dir_up_reg <= '0;
            car_dir_ok_reg <= '0;
            for (int i = 0; i < NUM_CARS; i++)
            begin
                car_floor_reg[i] <= '0;
                car_prev_reg[i]  <= '0;
                car_load_reg[i]  <= '0;
            end
        end
        else if (cmd.commit && best_ok_reg)
        begin
            car_prev_reg[best_idx_reg]   <= car_floor_reg[best_idx_reg];
            car_dir_up_reg[best_idx_reg] <= req_up_reg;
            car_dir_ok_reg[best_idx_reg] <= 1'b1;
            if (car_load_reg[best_idx_reg] != LOAD_MAX)
            begin
                car_load_reg[best_idx_reg] <= car_load_reg[best_idx_reg] + 1'b1;
            end
        end
        else if (cmd.execute && id_ok)
        begin
            if (item_reg.req_type == eds_pkg::REQ_STATUS)
            begin
                car_floor_reg[id_idx]  <= it_floor;
                car_known_reg[id_idx]  <= 1'b1;
                car_faulty_reg[id_idx] <= 1'b0;
            end
            else if (item_reg.req_type == eds_pkg::REQ_FAULT)
            begin
                car_faulty_reg[id_idx] <= 1'b1;
            end
        end
    end

    // Results of non-dispatch items.
    assign sts.has_result =
        (item_reg.req_type == eds_pkg::REQ_FLOOR && (item_reg.going_up ? up_full : dn_full))
        || (item_reg.req_type == eds_pkg::REQ_TRIP && id_ok);

    always_comb
    begin
        result = '0;
        if (cmd.commit)
        begin
            result.out_kind     = best_ok_reg ? eds_pkg::KIND_ASSIGN : eds_pkg::KIND_NO_CAR;
            result.car_id       = best_ok_reg ? 3'(best_idx_reg) : 3'd0;
            result.origin_floor = best_ok_reg ? 6'(car_floor_reg[best_idx_reg]) : 6'd0;
            result.pickup_floor = 6'(rq_reg.floor);
            result.target_floor = 6'(rq_reg.dest);
            result.dir_up       = req_up_reg;
            result.fault_tag    = rq_reg.tag;
        end
        else if (item_reg.req_type == eds_pkg::REQ_TRIP)
        begin
            result.out_kind     = eds_pkg::KIND_NOTIFY;
            result.car_id       = it_id;
            result.origin_floor = 6'(car_prev_reg[id_idx]);
            result.pickup_floor = 6'(it_pick);
            result.target_floor = 6'(it_dest);
        end
        else
        begin
            result.out_kind     = eds_pkg::KIND_DROPPED;
            result.pickup_floor = 6'(it_floor);
            result.target_floor = 6'(it_dest);
            result.dir_up       = item_reg.going_up;
            result.fault_tag    = item_reg.fault_flag;
        end
    end

    // A FIFO never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n) up_cnt_reg <= DEPTH_C)
        else $error("up FIFO count overflow");
    assert property (@(posedge clk) disable iff (!rst_n) dn_cnt_reg <= DEPTH_C)
        else $error("down FIFO count overflow");
    // Pops only happen when a request is present.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.pop |-> sts.has_request)
        else $error("pop from empty FIFOs");

endmodule

// File: hdl/eds_controller.sv
// ----------------------------------------------------------------------------
// eds_controller
// Sequences item acceptance, car scan and result delivery.
// ----------------------------------------------------------------------------
module eds_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  eds_pkg::in_item_t in_data,
    input  eds_pkg::out_item_t result,
    output eds_pkg::out_item_t out_data,
    output eds_pkg::eds_cmd_t cmd,
    input  eds_pkg::eds_sts_t sts
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_LOAD   = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_COMMIT = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg;
    logic       load_out;
    eds_pkg::out_item_t out_data_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    // The output register holds a result while the next beat is taken.
    assign in_ready  = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = (in_data.req_type == eds_pkg::REQ_DISPATCH) ? ST_FETCH : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!sts.has_result)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    cmd.execute = 1'b1;
                    load_out    = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                if (sts.has_request)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= result;
        end
    end

    // Only one datapath command is issued per cycle.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
        else $error("overlapping datapath commands");
    // A pending result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("result overwritten");
    // A commit always returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> state_reg == ST_IDLE)
        else $error("commit did not finish");

endmodule

// File: hdl/elevator_dispatch_scheduler.sv
// ----------------------------------------------------------------------------
// elevator_dispatch_scheduler
// Hall-call dispatcher with up/down request FIFOs and least-load car choice.
// ----------------------------------------------------------------------------
// One item is handled at a time. A floor request, status update, trip
// completion or fault report is captured, then executed before the block is
// ready for the next beat. A dispatch with a request waiting captures the
// beat, pops the FIFO head, waits for the FIFO memory read, compares one car
// per cycle in the search, and commits; with no request it returns to idle.
// A waiting result sits in an output register, so the next beat is accepted
// before it is taken; a new result waits until that register is free.
module elevator_dispatch_scheduler #(
    parameter int NUM_CARS   = 8,
    parameter int FIFO_DEPTH = 16,
    parameter int FLOOR_BITS = 6,
    parameter int LOAD_BITS  = 8
) (
    input logic       clk,
    input logic       rst_n,
    eds_stream_if.sink   in_ch,
    eds_stream_if.source out_ch,
    input logic       cfg_we,
    input logic [3:0] cfg_wdata
);
    eds_pkg::eds_cmd_t  cmd;
    eds_pkg::eds_sts_t  sts;
    eds_pkg::out_item_t result;

    eds_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .in_data   (in_ch.data),
        .result    (result),
        .out_data  (out_ch.data),
        .cmd       (cmd),
        .sts       (sts)
    );

    eds_datapath #(
        .NUM_CARS   (NUM_CARS),
        .FIFO_DEPTH (FIFO_DEPTH),
        .FLOOR_BITS (FLOOR_BITS),
        .LOAD_BITS  (LOAD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_ch.data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule
